@@ sv/mono_framebuffer_line_engine_top_macros.svh @@
// Assertion macros for the framebuffer line engine top level.
// Needs clk and rst in the scope of each use; define ASSERT_OFF to drop the checks.
`ifndef MONO_FRAMEBUFFER_LINE_ENGINE_TOP_MACROS_SVH
`define MONO_FRAMEBUFFER_LINE_ENGINE_TOP_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication.
`define MFLE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MFLE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define MFLE_ASSERT_IMP(lbl, ante, cons, msg)
`define MFLE_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

@@ sv/mfle_pkg.sv @@
// Shared constants, codes and types of the framebuffer line engine.
// No dependencies; imported by the command interface, front end, queue, back end, top level and testbench.
package mfle_pkg;

  localparam int PANEL_WIDTH    = 72;
  localparam int PANEL_HEIGHT   = 40;
  localparam int PAGE_COUNT     = (PANEL_HEIGHT + 7) / 8;
  localparam int BYTE_COUNT     = PANEL_WIDTH * PAGE_COUNT;
  localparam int ADDR_W         = $clog2(BYTE_COUNT);
  localparam int LAST_PAGE_BASE = (PAGE_COUNT - 1) * PANEL_WIDTH;
  localparam int LAST_ROWS      = PANEL_HEIGHT - 8 * (PAGE_COUNT - 1);
  localparam logic [7:0] LAST_PAGE_MASK = 8'((1 << LAST_ROWS) - 1);

  localparam int COORD_W     = 8;
  localparam int IDX_W       = 9;
  localparam int ERR_W       = COORD_W + 3;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    MODE_FILL  = 2'd0,
    MODE_PIXEL = 2'd1,
    MODE_LINE  = 2'd2,
    MODE_READ  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    OP_FILL,
    OP_LINE,
    OP_READ,
    OP_READ_BAD
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FILL,
    ST_LINE_RD,
    ST_LINE_WR,
    ST_READ_RD,
    ST_READ_DATA,
    ST_DONE
  } state_t;

  typedef struct packed {
    op_t                     op;
    logic [COORD_W-1:0]      x0;
    logic [COORD_W-1:0]      y0;
    logic [COORD_W-1:0]      x1;
    logic [COORD_W-1:0]      y1;
    logic [COORD_W-1:0]      dx;
    logic [COORD_W-1:0]      dy;
    logic                    sx_up;
    logic                    sy_up;
    logic                    value;
    logic signed [ERR_W-1:0] err0;
    logic [ADDR_W-1:0]       idx;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } slot_t;

endpackage

@@ sv/mfle_cmd_if.sv @@
// Command channel of the framebuffer line engine: valid/ready plus command fields.
// Depends on mfle_pkg for the field widths.
interface mfle_cmd_if;
  import mfle_pkg::*;

  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic [COORD_W-1:0] x_start;
  logic [COORD_W-1:0] y_start;
  logic [COORD_W-1:0] x_end;
  logic [COORD_W-1:0] y_end;
  logic               pixel_value;
  logic [IDX_W-1:0]   byte_index;

  modport source (
    output valid, mode, x_start, y_start, x_end, y_end, pixel_value, byte_index,
    input  ready
  );
  modport sink (
    input  valid, mode, x_start, y_start, x_end, y_end, pixel_value, byte_index,
    output ready
  );
endinterface

@@ sv/mfle_res_if.sv @@
// Result channel of the framebuffer line engine: valid/ready plus result fields.
// No dependencies.
interface mfle_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_byte;
  logic       clipped;

  modport source (output valid, read_byte, clipped, input ready);
  modport sink (input valid, read_byte, clipped, output ready);
endinterface

@@ sv/mfle_ram.sv @@
// Generic simple dual-port RAM, one write and one registered read per cycle.
// No dependencies.
module mfle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

@@ sv/mfle_front.sv @@
// Command front end: accepts beats and turns them into jobs for the queue.
// Depends on mfle_pkg and mfle_cmd_if.
module mfle_front (
  mfle_cmd_if.sink         cmd,
  input  logic             clearing,
  input  logic             enq_ready,
  output mfle_pkg::slot_t  enq
);
  import mfle_pkg::*;

  job_t               job;
  logic [COORD_W-1:0] x1;
  logic [COORD_W-1:0] y1;
  logic [COORD_W-1:0] dx;
  logic [COORD_W-1:0] dy;

  // A single pixel is a line whose end is its start.
  assign x1 = (mode_t'(cmd.mode) == MODE_PIXEL) ? cmd.x_start : cmd.x_end;
  assign y1 = (mode_t'(cmd.mode) == MODE_PIXEL) ? cmd.y_start : cmd.y_end;
  assign dx = (x1 > cmd.x_start) ? x1 - cmd.x_start : cmd.x_start - x1;
  assign dy = (y1 > cmd.y_start) ? y1 - cmd.y_start : cmd.y_start - y1;

  always_comb begin
    job.x0    = cmd.x_start;
    job.y0    = cmd.y_start;
    job.x1    = x1;
    job.y1    = y1;
    job.dx    = dx;
    job.dy    = dy;
    job.sx_up = cmd.x_start < x1;
    job.sy_up = cmd.y_start < y1;
    job.value = cmd.pixel_value;
    job.idx   = ADDR_W'(cmd.byte_index);
    if (dx > dy) begin
      job.err0 = ERR_W'(dx >> 1);
    end else begin
      job.err0 = -ERR_W'(dy >> 1);
    end
    case (mode_t'(cmd.mode))
      MODE_FILL:  job.op = OP_FILL;
      MODE_PIXEL: job.op = OP_LINE;
      MODE_LINE:  job.op = OP_LINE;
      MODE_READ:  job.op = (cmd.byte_index < BYTE_COUNT) ? OP_READ : OP_READ_BAD;
      default:    job.op = OP_READ_BAD;
    endcase
  end

  assign cmd.ready = enq_ready && !clearing;
  assign enq.valid = cmd.valid && !clearing;
  assign enq.job   = job;
endmodule

@@ sv/mfle_queue.sv @@
// Short job queue between the front end and the drawing back end.
// Depends on mfle_pkg.
module mfle_queue (
  input  logic             clk,
  input  logic             rst,
  input  mfle_pkg::slot_t  enq,
  output logic             enq_ready,
  input  logic             pop,
  output mfle_pkg::slot_t  deq
);
  import mfle_pkg::*;

  job_t              jobs [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              take;

  assign enq_ready = count != QCNT_W'(QUEUE_DEPTH);
  assign push      = enq.valid && enq_ready;
  assign take      = pop && (count != '0);
  assign deq.valid = count != '0;
  assign deq.job   = jobs[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (take) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !take) begin
        count <= count + 1'b1;
      end else if (take && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      jobs[wr_ptr] <= enq.job;
    end
  end
endmodule

@@ sv/mfle_back.sv @@
// Drawing back end: runs fill, line and read jobs on the page-ordered byte RAM.
// Depends on mfle_pkg, mfle_ram and mfle_res_if.
module mfle_back (
  input  logic             clk,
  input  logic             rst,
  input  mfle_pkg::slot_t  deq,
  output logic             pop,
  output logic             clearing,
  mfle_res_if.source       rsp
);
  import mfle_pkg::*;

  state_t                  state;
  state_t                  state_next;
  job_t                    cur;
  logic [COORD_W-1:0]      x;
  logic [COORD_W-1:0]      y;
  logic signed [ERR_W-1:0] err;
  logic [ADDR_W-1:0]       addr;
  logic                    clip;
  logic [7:0]              out_byte;
  logic                    rsp_valid;
  logic [7:0]              rsp_byte;
  logic                    rsp_clip;

  logic                    on_panel;
  logic [ADDR_W-1:0]       pix_addr;
  logic                    last_addr;
  logic                    line_end;
  logic                    step_x;
  logic                    step_y;
  logic signed [ERR_W-1:0] dxs;
  logic signed [ERR_W-1:0] dys;
  logic                    slot_free;

  logic                    wr_en;
  logic [ADDR_W-1:0]       wr_addr;
  logic [7:0]              wr_data;
  logic                    rd_en;
  logic [ADDR_W-1:0]       rd_addr;
  logic [7:0]              rd_data;
  logic [7:0]              patched;

  assign on_panel  = (x < PANEL_WIDTH) && (y < PANEL_HEIGHT);
  assign pix_addr  = ADDR_W'(y[COORD_W-1:3]) * ADDR_W'(PANEL_WIDTH) + ADDR_W'(x);
  assign last_addr = addr == ADDR_W'(BYTE_COUNT - 1);
  assign line_end  = (x == cur.x1) && (y == cur.y1);
  assign dxs       = ERR_W'(cur.dx);
  assign dys       = ERR_W'(cur.dy);
  assign step_x    = err > -dxs;
  assign step_y    = err < dys;
  assign slot_free = !rsp_valid || rsp.ready;

  always_comb begin
    patched         = rd_data;
    patched[y[2:0]] = cur.value;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (last_addr) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (deq.valid) begin
          case (deq.job.op)
            OP_FILL: state_next = ST_FILL;
            OP_LINE: state_next = ST_LINE_RD;
            OP_READ: state_next = ST_READ_RD;
            default: state_next = ST_DONE;
          endcase
        end
      end
      ST_FILL: begin
        if (last_addr) state_next = ST_DONE;
      end
      ST_LINE_RD:   state_next = ST_LINE_WR;
      ST_LINE_WR:   state_next = line_end ? ST_DONE : ST_LINE_RD;
      ST_READ_RD:   state_next = ST_READ_DATA;
      ST_READ_DATA: state_next = ST_DONE;
      ST_DONE: begin
        if (slot_free) state_next = ST_IDLE;
      end
      default:      state_next = ST_CLEAR;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    pop      = 1'b0;
    clearing = 1'b0;
    wr_en    = 1'b0;
    wr_addr  = addr;
    wr_data  = '0;
    rd_en    = 1'b0;
    rd_addr  = pix_addr;
    case (state)
      ST_CLEAR: begin
        clearing = 1'b1;
        wr_en    = 1'b1;
      end
      ST_IDLE: begin
        pop = deq.valid;
      end
      ST_FILL: begin
        wr_en   = 1'b1;
        wr_data = {8{cur.value}};
      end
      ST_LINE_RD: begin
        rd_en = on_panel;
      end
      ST_LINE_WR: begin
        wr_en   = on_panel;
        wr_addr = pix_addr;
        wr_data = patched;
      end
      ST_READ_RD: begin
        rd_en   = 1'b1;
        rd_addr = cur.idx;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      addr      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR || state == ST_FILL) begin
        addr <= last_addr ? '0 : addr + 1'b1;
      end
      if (state == ST_DONE && slot_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        cur      <= deq.job;
        x        <= deq.job.x0;
        y        <= deq.job.y0;
        err      <= deq.job.err0;
        clip     <= deq.job.op == OP_READ_BAD;
        out_byte <= '0;
      end
      ST_LINE_RD: begin
        if (!on_panel) clip <= 1'b1;
      end
      ST_LINE_WR: begin
        // Advance one Bresenham step; both axes test the old error term.
        if (!line_end) begin
          err <= err - (step_x ? dys : '0) + (step_y ? dxs : '0);
          if (step_x) x <= cur.sx_up ? x + 1'b1 : x - 1'b1;
          if (step_y) y <= cur.sy_up ? y + 1'b1 : y - 1'b1;
        end
      end
      ST_READ_DATA: begin
        // Drop rows below the panel on a partial last page.
        if (cur.idx >= ADDR_W'(LAST_PAGE_BASE)) begin
          out_byte <= rd_data & LAST_PAGE_MASK;
        end else begin
          out_byte <= rd_data;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          rsp_byte <= out_byte;
          rsp_clip <= clip;
        end
      end
      default: begin
      end
    endcase
  end

  mfle_ram #(
    .WIDTH (8),
    .DEPTH (BYTE_COUNT)
  ) u_frame (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rsp.valid     = rsp_valid;
  assign rsp.read_byte = rsp_byte;
  assign rsp.clipped   = rsp_clip;
endmodule

@@ sv/mono_framebuffer_line_engine_top.sv @@
// Top level of the monochrome framebuffer line engine: front end, job queue, back end.
// Depends on mfle_pkg, the channel interfaces, mfle_front, mfle_queue and mfle_back.
//
// Usage: commands arrive on cmd (valid/ready), one result beat per command leaves on rsp.
// The 72x40 frame is held as 360 page-ordered bytes in one RAM; a command is fill,
// set pixel, draw line or read display byte.
// A bad read index touches no RAM byte and comes back with clipped set.
// Each line pixel is a read-modify-write of one RAM byte; a fill writes
// one byte per cycle. Results come out in command order.
// Up to two commands wait in the queue, so the front end keeps taking beats while
// the back end draws and while a finished result waits in the output register.
// After reset all 360 RAM bytes are swept to zero; cmd.ready stays low for that
// sweep. A stalled rsp holds its beat, the back end waits in its done state and the
// queue fills, after which cmd.ready drops.
`include "mono_framebuffer_line_engine_top_macros.svh"

module mono_framebuffer_line_engine_top (
  input  logic       clk,
  input  logic       rst,
  mfle_cmd_if.sink   cmd,
  mfle_res_if.source rsp
);
  import mfle_pkg::*;

  slot_t enq;
  slot_t deq;
  logic  enq_ready;
  logic  pop;
  logic  clearing;

  mfle_front u_front (
    .cmd       (cmd),
    .clearing  (clearing),
    .enq_ready (enq_ready),
    .enq       (enq)
  );

  mfle_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .enq       (enq),
    .enq_ready (enq_ready),
    .pop       (pop),
    .deq       (deq)
  );

  mfle_back u_back (
    .clk      (clk),
    .rst      (rst),
    .deq      (deq),
    .pop      (pop),
    .clearing (clearing),
    .rsp      (rsp)
  );

  `MFLE_ASSERT_IMP(a_no_accept_in_clear, clearing, !cmd.ready, "command taken during clear")
  `MFLE_ASSERT_IMP(a_pop_nonempty, pop, deq.valid, "queue popped while empty")
  `MFLE_ASSERT_NXT(a_accept_queued, (cmd.valid && cmd.ready), deq.valid, "accepted beat lost")
endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// Testbench for the monochrome framebuffer line engine: directed and random command traffic.
// Depends on mfle_pkg, mfle_cmd_if, mfle_res_if and mono_framebuffer_line_engine_top.
module tb;
  import mfle_pkg::*;

  typedef struct {
    logic [7:0] read_byte;
    logic       clipped;
  } result_t;

  logic clk;
  logic rst;

  mfle_cmd_if cmd ();
  mfle_res_if rsp ();

  mono_framebuffer_line_engine_top DUT (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .rsp (rsp)
  );

  // Shadow copy of the frame, one packed row per panel row.
  bit [PANEL_WIDTH-1:0] frame_rows [PANEL_HEIGHT];
  result_t              pending_results [$];
  int                   mismatch_count = 0;
  int                   send_idle_pct  = 22;
  int                   recv_idle_pct  = 88;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The slowest legal run of 1652 commands stays far below this timeout.
  initial begin
    #40ms;
    $display("tb NOT OK");
    $finish;
  end

  task automatic report_mismatch(string what, int got, int want);
    mismatch_count++;
    $display("MISMATCH at %0t: %s got %0d want %0d", $realtime, what, got, want);
  endtask

  function automatic bit plot_pixel(int col, int row, bit v);
    if (col < 0 || row < 0 || col >= PANEL_WIDTH || row >= PANEL_HEIGHT) return 1'b1;
    frame_rows[row][col] = v;
    return 1'b0;
  endfunction

  function automatic bit trace_line(int x0, int y0, int x1, int y1, bit v);
    int dx, dy, sx, sy, err, e;
    bit clip;
    dx   = (x1 > x0) ? x1 - x0 : x0 - x1;
    dy   = (y1 > y0) ? y1 - y0 : y0 - y1;
    sx   = (x0 < x1) ? 1 : -1;
    sy   = (y0 < y1) ? 1 : -1;
    err  = ((dx > dy) ? dx : -dy) / 2;
    clip = 1'b0;
    while (1'b1) begin
      clip |= plot_pixel(x0, y0, v);
      if (x0 == x1 && y0 == y1) break;
      e = err;
      if (e > -dx) begin
        err -= dy;
        x0  += sx;
      end
      if (e < dy) begin
        err += dx;
        y0  += sy;
      end
    end
    return clip;
  endfunction

  function automatic logic [7:0] pack_column(int idx);
    int page, col, row;
    logic [7:0] b;
    page = idx / PANEL_WIDTH;
    col  = idx % PANEL_WIDTH;
    b    = '0;
    for (int j = 0; j < 8; j++) begin
      row = page * 8 + j;
      if (row < PANEL_HEIGHT && frame_rows[row][col]) b[j] = 1'b1;
    end
    return b;
  endfunction

  function automatic result_t apply_command(mode_t m, logic [7:0] xs, logic [7:0] ys,
                                            logic [7:0] xe, logic [7:0] ye, logic v,
                                            logic [8:0] idx);
    result_t r;
    r.read_byte = 8'h00;
    r.clipped   = 1'b0;
    case (m)
      MODE_FILL: begin
        for (int row = 0; row < PANEL_HEIGHT; row++) frame_rows[row] = {PANEL_WIDTH{v}};
      end
      MODE_PIXEL: r.clipped = plot_pixel(xs, ys, v);
      MODE_LINE:  r.clipped = trace_line(xs, ys, xe, ye, v);
      MODE_READ: begin
        if (idx < BYTE_COUNT) r.read_byte = pack_column(idx);
        else r.clipped = 1'b1;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // Drive one command beat and hold it until accepted; predict at the accepting edge.
  task automatic send_cmd(mode_t m, logic [7:0] xs, logic [7:0] ys, logic [7:0] xe,
                          logic [7:0] ye, logic v, logic [8:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd.valid <= 1'b0;
      @(posedge clk);
    end
    cmd.valid       <= 1'b1;
    cmd.mode        <= m;
    cmd.x_start     <= xs;
    cmd.y_start     <= ys;
    cmd.x_end       <= xe;
    cmd.y_end       <= ye;
    cmd.pixel_value <= v;
    cmd.byte_index  <= idx;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
    pending_results.push_back(apply_command(m, xs, ys, xe, ye, v, idx));
  endtask

  // Check each result beat against the oldest prediction; stall at random.
  initial begin
    result_t want;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp.valid && rsp.ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result, read_byte", rsp.read_byte, 0);
        end else begin
          want = pending_results.pop_front();
          if (rsp.read_byte !== want.read_byte)
            report_mismatch("read_byte", rsp.read_byte, want.read_byte);
          if (rsp.clipped !== want.clipped)
            report_mismatch("clipped", rsp.clipped, want.clipped);
        end
      end
      rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic logic [7:0] rand_coord(int span);
    if ($urandom_range(99) < 12) return 8'($urandom_range(255));
    return 8'($urandom_range(span + 7));
  endfunction

  function automatic logic [8:0] rand_index();
    if ($urandom_range(99) < 80) return 9'($urandom_range(BYTE_COUNT - 1));
    return 9'($urandom_range(511));
  endfunction

  task automatic run_random_mix(int count);
    int pick;
    mode_t m;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 2) m = MODE_FILL;
      else if (pick < 32) m = MODE_PIXEL;
      else if (pick < 62) m = MODE_LINE;
      else m = MODE_READ;
      // Unused fields carry random junk that the block must ignore.
      send_cmd(m, rand_coord(PANEL_WIDTH), rand_coord(PANEL_HEIGHT), rand_coord(PANEL_WIDTH),
               rand_coord(PANEL_HEIGHT), 1'($urandom_range(1)), rand_index());
    end
  endtask

  task automatic test_fill_and_read();
    send_cmd(MODE_FILL, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 9'd0);
    send_cmd(MODE_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 9'd0);
    send_cmd(MODE_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 9'(BYTE_COUNT - 1));
    send_cmd(MODE_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 9'(BYTE_COUNT));
    send_cmd(MODE_READ, 8'hff, 8'hff, 8'hff, 8'hff, 1'b1, 9'd511);
    send_cmd(MODE_FILL, 8'hff, 8'hff, 8'hff, 8'hff, 1'b0, 9'd511);
    send_cmd(MODE_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 9'd0);
  endtask

  task automatic test_pixels();
    send_cmd(MODE_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 9'd0);
    send_cmd(MODE_PIXEL, 8'(PANEL_WIDTH - 1), 8'(PANEL_HEIGHT - 1), 8'd0, 8'd0, 1'b1, 9'd0);
    send_cmd(MODE_PIXEL, 8'(PANEL_WIDTH), 8'd5, 8'd0, 8'd0, 1'b1, 9'd0);
    send_cmd(MODE_PIXEL, 8'd3, 8'(PANEL_HEIGHT), 8'd0, 8'd0, 1'b1, 9'd0);
    send_cmd(MODE_PIXEL, 8'hff, 8'hff, 8'd0, 8'd0, 1'b1, 9'd0);
    send_cmd(MODE_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 9'd0);
    send_cmd(MODE_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 9'(BYTE_COUNT - 1));
  endtask

  task automatic test_lines();
    send_cmd(MODE_LINE, 8'd9, 8'd9, 8'd9, 8'd9, 1'b1, 9'd0);
    send_cmd(MODE_LINE, 8'd0, 8'd0, 8'(PANEL_WIDTH - 1), 8'(PANEL_HEIGHT - 1), 1'b1, 9'd0);
    send_cmd(MODE_LINE, 8'(PANEL_WIDTH - 1), 8'd0, 8'd0, 8'(PANEL_HEIGHT - 1), 1'b1, 9'd0);
    send_cmd(MODE_LINE, 8'd10, 8'(PANEL_HEIGHT - 1), 8'd12, 8'd0, 1'b1, 9'd0);
    send_cmd(MODE_LINE, 8'd60, 8'd30, 8'hff, 8'd200, 1'b1, 9'd0);
    send_cmd(MODE_LINE, 8'hff, 8'hff, 8'd0, 8'd0, 1'b0, 9'd0);
    send_cmd(MODE_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 9'(PANEL_WIDTH + 9));
    send_cmd(MODE_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 9'd150);
  endtask

  task automatic test_random_slow_receiver();
    send_idle_pct = 22;
    recv_idle_pct = 88;
    run_random_mix(540);
  endtask

  task automatic test_random_slow_sender();
    send_idle_pct = 88;
    recv_idle_pct = 22;
    run_random_mix(540);
  endtask

  task automatic test_random_streaming();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random_mix(550);
  endtask

  initial begin
    rst             <= 1'b1;
    cmd.valid       <= 1'b0;
    cmd.mode        <= MODE_FILL;
    cmd.x_start     <= '0;
    cmd.y_start     <= '0;
    cmd.x_end       <= '0;
    cmd.y_end       <= '0;
    cmd.pixel_value <= 1'b0;
    cmd.byte_index  <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_fill_and_read();
    test_pixels();
    test_lines();
    test_random_slow_receiver();
    test_random_slow_sender();
    test_random_streaming();
    cmd.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    // Drain: every expected beat is in, so catch any stray beat that follows.
    repeat (400) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+sv
sv/mfle_pkg.sv
sv/mfle_cmd_if.sv
sv/mfle_res_if.sv
sv/mfle_ram.sv
sv/mfle_front.sv
sv/mfle_queue.sv
sv/mfle_back.sv
sv/mono_framebuffer_line_engine_top.sv
verif/tb.sv
